// ===== hw/rtl/rtks_pkg.sv =====
// ----------------------------------------------------------------------------
// rtks_pkg: shared types and constants for the range top-k sum block
// sizes of the node store, version table and rank table, beat structs,
// the node record and the sequencer states
// ----------------------------------------------------------------------------
package rtks_pkg;

  localparam int MAX_ITEMS = 4096;
  localparam int MAX_RANKS = 4096;
  localparam int NODE_POOL = 53249;

  localparam int POS_W  = 13;   // positions, counts, span register
  localparam int RANK_W = 12;
  localparam int VAL_W  = 32;
  localparam int NSUM_W = 44;
  localparam int OSUM_W = 45;
  localparam int NID_W  = 16;

  typedef struct packed {
    logic                     opcode;
    logic [RANK_W-1:0]        rank;
    logic signed [VAL_W-1:0]  item_value;
    logic [POS_W-1:0]         range_left;
    logic [POS_W-1:0]         range_right;
    logic [POS_W-1:0]         take_count;
  } in_item_t;

  typedef struct packed {
    logic signed [OSUM_W-1:0] top_sum;
    logic                     short_flag;
    logic                     error_flag;
  } out_item_t;

  typedef struct packed {
    logic signed [NSUM_W-1:0] sum;
    logic [POS_W-1:0]         count;
    logic [NID_W-1:0]         lc;
    logic [NID_W-1:0]         rc;
  } node_t;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_ROOT,
    S_A_PREV,
    S_A_RD,
    S_A_WR,
    S_Q_RA,
    S_Q_RB,
    S_Q_NA,
    S_Q_CHK,
    S_Q_TEST,
    S_Q_R2,
    S_Q_R3,
    S_Q_L2,
    S_Q_L3,
    S_Q_MUL,
    S_Q_ACC,
    S_RES
  } state_t;

  // effective leaf span: zero acts as one, clipped to the rank table size
  function automatic logic [POS_W-1:0] span_of(input logic [POS_W-1:0] rc);
    logic [POS_W-1:0] m;
    m = rc;
    if (rc == '0) m = POS_W'(1);
    else if (rc > POS_W'(MAX_RANKS)) m = POS_W'(MAX_RANKS);
    return m;
  endfunction

endpackage

// ===== hw/rtl/rtks_node_mem.sv =====
// ----------------------------------------------------------------------------
// rtks_node_mem: tree node store
// one write port, one registered read port; node zero always reads as empty
// ----------------------------------------------------------------------------
module rtks_node_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [rtks_pkg::NID_W-1:0] waddr,
  input  rtks_pkg::node_t            wdata,
  input  logic                       re,
  input  logic [rtks_pkg::NID_W-1:0] raddr,
  output rtks_pkg::node_t            rdata
);

  rtks_pkg::node_t mem [0:rtks_pkg::NODE_POOL-1];
  rtks_pkg::node_t q;
  logic            q_zero;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q      <= mem[raddr];
      q_zero <= (raddr == '0);
    end
  end

  // the empty node is never written
  assign rdata = q_zero ? '0 : q;

endmodule

// ===== hw/rtl/range_topk_sum_query.sv =====
// ----------------------------------------------------------------------------
// range_topk_sum_query: sum of the k largest values over a position range
// persistent segment tree over value ranks, one version per appended item
// ----------------------------------------------------------------------------
// An append beat (opcode 0) adds one (rank, item_value) item and builds a new
// tree version by copying one node per level; it gives no result unless it
// is dropped (rank outside the span or 4096 items held), which gives a result
// with error_flag. A query beat (opcode 1) descends the versions at
// range_left-1 and range_right side by side and returns the sum of the
// take_count largest values. One item is in work at a time and in_ready is
// low meanwhile. The tree has ceil(log2 span)+1 levels, at most 13; an
// append reads then writes each node of its path on the single node store,
// and a query reads the two right children at each level, then the two
// left children where the descent goes left, and ends with a leaf multiply.
// Results sit in an output register, so the next item can start while a
// result beat waits. Writing rank_count empties the sequence. No clearing
// pass is needed after reset: nodes and versions are written before reads.
// ----------------------------------------------------------------------------
module range_topk_sum_query (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rtks_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rtks_pkg::out_item_t        out_data,
  input  logic                       cfg_wen,
  input  logic [rtks_pkg::POS_W-1:0] cfg_wdata
);

  localparam int PW = rtks_pkg::POS_W;
  localparam int RW = rtks_pkg::RANK_W;
  localparam int NW = rtks_pkg::NID_W;
  localparam int SW = rtks_pkg::NSUM_W;
  localparam int OW = rtks_pkg::OSUM_W;

  rtks_pkg::state_t state, state_next;

  // configuration and sequence bookkeeping
  logic [PW-1:0] rank_count;
  logic [PW-1:0] span;
  logic [PW-1:0] item_total;
  logic [NW-1:0] next_free;   // last node handed out

  // per-item working registers
  logic [RW-1:0]           ap_rank;
  logic signed [31:0]      ap_val;
  logic [PW-1:0]           q_left, q_right, k;
  logic [RW-1:0]           lo, hi;
  logic [NW-1:0]           prev, root_id;
  rtks_pkg::node_t         a_node, b_node, ra_node;
  logic signed [OW-1:0]    acc, prod;
  rtks_pkg::out_item_t     res;

  // memories
  logic [NW-1:0] vroot [0:rtks_pkg::MAX_ITEMS];
  logic [NW-1:0] vr_q_raw, vr_q;
  logic          vr_zero;
  logic          vr_re, vr_we;
  logic [PW-1:0] vr_raddr, vr_waddr;

  logic signed [31:0] rvals [0:rtks_pkg::MAX_RANKS-1];
  logic signed [31:0] rv_q;
  logic               rv_re, rv_we;

  logic            nm_re, nm_we;
  logic [NW-1:0]   nm_raddr, nm_waddr;
  rtks_pkg::node_t nm_wdata, nm_q;

  // handy combinational terms
  logic                   accept, out_load;
  logic                   ap_bad, qy_bad;
  logic [PW-1:0]          mid_sum;
  logic [RW-1:0]          mid;
  logic                   leaf, go_left;
  logic signed [PW:0]     total, rcnt, k_s;
  logic signed [OW:0]     mul_full;
  logic signed [OW-1:0]   diff_top;

  assign span     = rtks_pkg::span_of(rank_count);
  assign in_ready = (state == rtks_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == rtks_pkg::S_RES) && (!out_valid || out_ready);

  // the node pool holds 13 nodes per item, so it never runs out; only the span and item limit drop
  assign ap_bad = ({1'b0, in_data.rank} >= span) ||
                  (item_total >= PW'(rtks_pkg::MAX_ITEMS));
  assign qy_bad = (in_data.range_left == '0) ||
                  (in_data.range_left > in_data.range_right) ||
                  (in_data.range_right > item_total);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[PW-1:1];
  assign leaf    = (lo >= hi);
  assign go_left = (ap_rank <= mid);

  assign k_s      = $signed({1'b0, k});
  assign total    = $signed({1'b0, nm_q.count}) - $signed({1'b0, a_node.count});
  assign rcnt     = $signed({1'b0, nm_q.count}) - $signed({1'b0, ra_node.count});
  assign mul_full = k_s * rv_q;
  assign diff_top = OW'(nm_q.sum) - OW'(a_node.sum);

  // version roots: entry zero is the empty tree
  always_ff @(posedge clk) begin
    if (vr_we) begin
      vroot[vr_waddr] <= root_id;
    end
    if (vr_re) begin
      vr_q_raw <= vroot[vr_raddr];
      vr_zero  <= (vr_raddr == '0);
    end
  end
  assign vr_q = vr_zero ? '0 : vr_q_raw;

  // value held by each rank
  always_ff @(posedge clk) begin
    if (rv_we) begin
      rvals[in_data.rank] <= in_data.item_value;
    end
    if (rv_re) begin
      rv_q <= rvals[lo];
    end
  end

  rtks_node_mem u_nodes (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .re    (nm_re),
    .raddr (nm_raddr),
    .rdata (nm_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rtks_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == rtks_pkg::OP_APPEND) begin
            state_next = ap_bad ? rtks_pkg::S_RES : rtks_pkg::S_A_ROOT;
          end else begin
            state_next = qy_bad ? rtks_pkg::S_RES : rtks_pkg::S_Q_RA;
          end
        end
      end
      rtks_pkg::S_A_ROOT: state_next = rtks_pkg::S_A_PREV;
      rtks_pkg::S_A_PREV: state_next = rtks_pkg::S_A_RD;
      rtks_pkg::S_A_RD:   state_next = rtks_pkg::S_A_WR;
      rtks_pkg::S_A_WR:   state_next = leaf ? rtks_pkg::S_IDLE : rtks_pkg::S_A_RD;
      rtks_pkg::S_Q_RA:   state_next = rtks_pkg::S_Q_RB;
      rtks_pkg::S_Q_RB:   state_next = rtks_pkg::S_Q_NA;
      rtks_pkg::S_Q_NA:   state_next = rtks_pkg::S_Q_CHK;
      rtks_pkg::S_Q_CHK:  state_next = (k_s > total) ? rtks_pkg::S_RES : rtks_pkg::S_Q_TEST;
      rtks_pkg::S_Q_TEST: begin
        if (!leaf && k != '0) state_next = rtks_pkg::S_Q_R2;
        else if (k != '0)     state_next = rtks_pkg::S_Q_MUL;
        else                  state_next = rtks_pkg::S_RES;
      end
      rtks_pkg::S_Q_R2:   state_next = rtks_pkg::S_Q_R3;
      rtks_pkg::S_Q_R3:   state_next = (rcnt >= k_s) ? rtks_pkg::S_Q_TEST : rtks_pkg::S_Q_L2;
      rtks_pkg::S_Q_L2:   state_next = rtks_pkg::S_Q_L3;
      rtks_pkg::S_Q_L3:   state_next = rtks_pkg::S_Q_TEST;
      rtks_pkg::S_Q_MUL:  state_next = rtks_pkg::S_Q_ACC;
      rtks_pkg::S_Q_ACC:  state_next = rtks_pkg::S_RES;
      rtks_pkg::S_RES:    state_next = out_load ? rtks_pkg::S_IDLE : rtks_pkg::S_RES;
      default:            state_next = rtks_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    vr_re    = 1'b0;
    vr_raddr = item_total;
    vr_we    = 1'b0;
    vr_waddr = item_total + PW'(1);
    rv_re    = 1'b0;
    rv_we    = 1'b0;
    nm_re    = 1'b0;
    nm_raddr = prev;
    nm_we    = 1'b0;
    nm_waddr = next_free + NW'(1);
    nm_wdata = nm_q;
    case (state)
      rtks_pkg::S_IDLE: begin
        rv_we = accept && (in_data.opcode == rtks_pkg::OP_APPEND) && !ap_bad;
      end
      rtks_pkg::S_A_ROOT: vr_re = 1'b1;
      rtks_pkg::S_A_RD:   nm_re = 1'b1;
      rtks_pkg::S_A_WR: begin
        // path node: prev copied, one more item below it
        nm_we          = 1'b1;
        nm_wdata.count = nm_q.count + PW'(1);
        nm_wdata.sum   = nm_q.sum + SW'(ap_val);
        if (!leaf) begin
          if (go_left) nm_wdata.lc = next_free + NW'(2);
          else         nm_wdata.rc = next_free + NW'(2);
        end
        vr_we = leaf;
      end
      rtks_pkg::S_Q_RA: begin
        vr_re    = 1'b1;
        vr_raddr = q_left - PW'(1);
      end
      rtks_pkg::S_Q_RB: begin
        vr_re    = 1'b1;
        vr_raddr = q_right;
        nm_re    = 1'b1;
        nm_raddr = vr_q;
      end
      rtks_pkg::S_Q_NA: begin
        nm_re    = 1'b1;
        nm_raddr = vr_q;
      end
      rtks_pkg::S_Q_TEST: begin
        nm_re    = !leaf && (k != '0);
        nm_raddr = a_node.rc;
        rv_re    = leaf && (k != '0);
      end
      rtks_pkg::S_Q_R2: begin
        nm_re    = 1'b1;
        nm_raddr = b_node.rc;
      end
      rtks_pkg::S_Q_R3: begin
        nm_re    = (rcnt < k_s);
        nm_raddr = a_node.lc;
      end
      rtks_pkg::S_Q_L2: begin
        nm_re    = 1'b1;
        nm_raddr = b_node.lc;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rtks_pkg::S_IDLE;
      rank_count <= PW'(rtks_pkg::MAX_RANKS);
      item_total <= '0;
      next_free  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        // new span: drop every version
        rank_count <= cfg_wdata;
        item_total <= '0;
        next_free  <= '0;
      end else if (state == rtks_pkg::S_A_WR) begin
        next_free <= next_free + NW'(1);
        if (leaf) item_total <= item_total + PW'(1);
      end
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (out_load) out_data <= res;
    case (state)
      rtks_pkg::S_IDLE: begin
        ap_rank <= in_data.rank;
        ap_val  <= in_data.item_value;
        q_left  <= in_data.range_left;
        q_right <= in_data.range_right;
        k       <= in_data.take_count;
        lo      <= '0;
        hi      <= RW'(span - PW'(1));
        acc     <= '0;
        res     <= '{top_sum: '0, short_flag: 1'b0, error_flag: 1'b1};
      end
      rtks_pkg::S_A_PREV: begin
        prev    <= vr_q;
        root_id <= next_free + NW'(1);
      end
      rtks_pkg::S_A_WR: begin
        if (go_left) begin
          prev <= nm_q.lc;
          hi   <= mid;
        end else begin
          prev <= nm_q.rc;
          lo   <= mid + RW'(1);
        end
      end
      rtks_pkg::S_Q_NA: a_node <= nm_q;
      rtks_pkg::S_Q_CHK: begin
        b_node <= nm_q;
        // range holds fewer than k: whole range sum
        res    <= '{top_sum: diff_top, short_flag: 1'b1, error_flag: 1'b0};
      end
      rtks_pkg::S_Q_TEST: begin
        res <= '{top_sum: acc, short_flag: 1'b0, error_flag: 1'b0};
      end
      rtks_pkg::S_Q_R2: ra_node <= nm_q;
      rtks_pkg::S_Q_R3: begin
        if (rcnt >= k_s) begin
          a_node <= ra_node;
          b_node <= nm_q;
          lo     <= mid + RW'(1);
        end else begin
          acc <= acc + OW'(nm_q.sum) - OW'(ra_node.sum);
          k   <= k - rcnt[PW-1:0];
          hi  <= mid;
        end
      end
      rtks_pkg::S_Q_L2:  a_node <= nm_q;
      rtks_pkg::S_Q_L3:  b_node <= nm_q;
      rtks_pkg::S_Q_MUL: prod <= mul_full[OW-1:0];
      rtks_pkg::S_Q_ACC: begin
        res <= '{top_sum: acc + prod, short_flag: 1'b0, error_flag: 1'b0};
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/rtks_checker.sv =====
// ----------------------------------------------------------------------------
// rtks_checker: port-level checks for the range top-k sum block
// watches the handshakes and result flags, attached by bind
// ----------------------------------------------------------------------------
module rtks_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input rtks_pkg::out_item_t        out_data
);

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // an error result carries no sum and no short flag
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_flag |-> out_data.top_sum == '0 && !out_data.short_flag)
    else $error("error result with payload");

  // a new result only appears while the block is busy
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared from idle");

endmodule

bind range_topk_sum_query rtks_checker u_rtks_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the range top-k sum block
// drives append and query beats over valid/ready, keeps its own copy of the
// persistent tree to work out each expected result, and compares every
// result beat field by field under several idling and span settings
// ----------------------------------------------------------------------------
module tb_top;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  rtks_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  rtks_pkg::out_item_t out_data;
  logic cfg_wen;
  logic [rtks_pkg::POS_W-1:0] cfg_wdata;

  range_topk_sum_query uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  // shadow tree: node store, version roots, rank values and counters
  longint tree_sum [rtks_pkg::NODE_POOL];
  int     tree_cnt [rtks_pkg::NODE_POOL];
  int     tree_lc [rtks_pkg::NODE_POOL];
  int     tree_rc [rtks_pkg::NODE_POOL];
  int     ver_root [rtks_pkg::MAX_ITEMS+1];
  longint rank_val [rtks_pkg::MAX_RANKS];
  int     last_node;
  int     seq_len;
  int     span_reg;

  rtks_pkg::out_item_t expected_q[$];
  int errors;
  int beats_sent;
  int results_seen;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous fixed limit on the whole run
  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic int eff_span();
    int m;
    m = span_reg;
    if (m == 0) m = 1;
    if (m > rtks_pkg::MAX_RANKS) m = rtks_pkg::MAX_RANKS;
    return m;
  endfunction

  function automatic void clear_tree();
    tree_sum[0] = 0;
    tree_cnt[0] = 0;
    tree_lc[0] = 0;
    tree_rc[0] = 0;
    ver_root[0] = 0;
    last_node = 0;
    seq_len = 0;
  endfunction

  // append: one fresh node per level; only a dropped append yields a beat
  function automatic bit append_item(int rank, longint v, output rtks_pkg::out_item_t r);
    int m, lo, hi, len, prev, id, mid, i, p;
    int path [16];
    bit went_r [16];
    m = eff_span();
    r = '0;
    r.error_flag = 1'b1;
    if (rank >= m || seq_len >= rtks_pkg::MAX_ITEMS) return 1'b1;
    lo = 0; hi = m - 1; len = 1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (rank <= mid) hi = mid; else lo = mid + 1;
      len++;
    end
    if (last_node + len > rtks_pkg::NODE_POOL - 1) return 1'b1;
    rank_val[rank] = v;
    prev = ver_root[seq_len];
    lo = 0; hi = m - 1;
    for (i = 0; i < len; i++) begin
      last_node++;
      id = last_node;
      tree_sum[id] = tree_sum[prev];
      tree_cnt[id] = tree_cnt[prev];
      tree_lc[id] = tree_lc[prev];
      tree_rc[id] = tree_rc[prev];
      path[i] = id;
      went_r[i] = 1'b0;
      if (i > 0) begin
        if (went_r[i-1]) tree_rc[path[i-1]] = id;
        else tree_lc[path[i-1]] = id;
      end
      if (lo >= hi) begin
        tree_cnt[id] += 1;
        tree_sum[id] += v;
        break;
      end
      mid = lo + (hi - lo) / 2;
      if (rank <= mid) begin
        prev = tree_lc[prev];
        hi = mid;
      end else begin
        prev = tree_rc[prev];
        lo = mid + 1;
        went_r[i] = 1'b1;
      end
    end
    // rebuild counts and sums on the way back up
    for (i = len - 2; i >= 0; i--) begin
      p = path[i];
      tree_cnt[p] = tree_cnt[tree_lc[p]] + tree_cnt[tree_rc[p]];
      tree_sum[p] = tree_sum[tree_lc[p]] + tree_sum[tree_rc[p]];
    end
    ver_root[seq_len+1] = path[0];
    seq_len++;
    return 1'b0;
  endfunction

  // query: walk both versions together, higher-rank half first
  function automatic rtks_pkg::out_item_t top_sum_of(int left, int right, int k);
    rtks_pkg::out_item_t r;
    int a, b, lo, hi, mid, ra, rb, rcnt;
    longint acc;
    r = '0;
    acc = 0;
    if (left == 0 || left > right || right > seq_len) begin
      r.error_flag = 1'b1;
      return r;
    end
    a = ver_root[left-1];
    b = ver_root[right];
    if (k > tree_cnt[b] - tree_cnt[a]) begin
      r.top_sum = rtks_pkg::OSUM_W'(tree_sum[b] - tree_sum[a]);
      r.short_flag = 1'b1;
      return r;
    end
    lo = 0;
    hi = eff_span() - 1;
    while (lo < hi && k > 0) begin
      mid = lo + (hi - lo) / 2;
      ra = tree_rc[a];
      rb = tree_rc[b];
      rcnt = tree_cnt[rb] - tree_cnt[ra];
      if (rcnt >= k) begin
        a = ra; b = rb; lo = mid + 1;
      end else begin
        acc += tree_sum[rb] - tree_sum[ra];
        k -= rcnt;
        a = tree_lc[a];
        b = tree_lc[b];
        hi = mid;
      end
    end
    // partial take at a leaf uses the latest value of that rank
    if (k > 0) acc += longint'(k) * rank_val[lo];
    r.top_sum = rtks_pkg::OSUM_W'(acc);
    return r;
  endfunction

  task automatic send_beat(rtks_pkg::in_item_t it);
    rtks_pkg::out_item_t r;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (it.opcode == rtks_pkg::OP_APPEND) begin
      if (append_item(int'(it.rank), longint'(it.item_value), r)) expected_q = {expected_q, r};
    end else begin
      r = top_sum_of(int'(it.range_left), int'(it.range_right), int'(it.take_count));
      expected_q = {expected_q, r};
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, out_data);
      end else begin
        rtks_pkg::out_item_t e;
        e = expected_q.pop_front();
        if (out_data.top_sum !== e.top_sum) begin
          errors++;
          $display("%0t: top_sum expected %0d got %0d", $time, e.top_sum, out_data.top_sum);
        end
        if (out_data.short_flag !== e.short_flag) begin
          errors++;
          $display("%0t: short_flag expected %b got %b", $time, e.short_flag,
                   out_data.short_flag);
        end
        if (out_data.error_flag !== e.error_flag) begin
          errors++;
          $display("%0t: error_flag expected %b got %b", $time, e.error_flag,
                   out_data.error_flag);
        end
      end
    end
  end

  // drain, let a silent append finish, then write the span register
  task automatic set_span(int v);
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_wdata = rtks_pkg::POS_W'(v);
    @(negedge clk);
    cfg_wen = 1'b0;
    span_reg = v;
    clear_tree();
  endtask

  function automatic rtks_pkg::in_item_t append_beat(int rank, int v);
    rtks_pkg::in_item_t it;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};   // unused fields carry noise
    it = noise[$bits(rtks_pkg::in_item_t)-1:0];
    it.opcode = rtks_pkg::OP_APPEND;
    it.rank = rtks_pkg::RANK_W'(rank);
    it.item_value = v;
    return it;
  endfunction

  function automatic rtks_pkg::in_item_t query_beat(int l, int r, int k);
    rtks_pkg::in_item_t it;
    logic [95:0] noise;
    noise = {$urandom, $urandom, $urandom};
    it = noise[$bits(rtks_pkg::in_item_t)-1:0];
    it.opcode = rtks_pkg::OP_QUERY;
    it.range_left = rtks_pkg::POS_W'(l);
    it.range_right = rtks_pkg::POS_W'(r);
    it.take_count = rtks_pkg::POS_W'(k);
    return it;
  endfunction

  // extremes, every operation and each corner of the query
  task automatic test_directed();
    send_beat(query_beat(1, 1, 1));                 // empty sequence
    send_beat(append_beat(4095, 32'h7fffffff));
    send_beat(append_beat(0, 32'h80000000));
    send_beat(append_beat(4095, 32'h7ffffffe));     // rank re-appended
    send_beat(append_beat(2048, -5));
    send_beat(query_beat(1, 4, 1));
    send_beat(query_beat(1, 4, 2));                 // both items of one leaf taken
    send_beat(query_beat(1, 4, 4));
    send_beat(query_beat(1, 4, 5));                 // take above items held
    send_beat(query_beat(2, 3, 8191));
    send_beat(query_beat(1, 4, 0));                 // zero take
    send_beat(query_beat(0, 2, 1));                 // left of zero
    send_beat(query_beat(3, 2, 1));                 // left above right
    send_beat(query_beat(1, 5, 1));                 // right beyond sequence
    send_beat(query_beat(4096, 4096, 1));
    send_beat(query_beat(3, 3, 1));
    set_span(3);
    send_beat(append_beat(3, 7));                   // rank outside span
    send_beat(append_beat(2, 9));
    send_beat(query_beat(1, 1, 1));
    set_span(0);                                    // acts as a span of one
    send_beat(append_beat(0, 11));
    send_beat(append_beat(1, 12));
    send_beat(query_beat(1, 1, 1));
    set_span(8191);                                 // clipped to full span
    send_beat(append_beat(4095, 13));
    send_beat(query_beat(1, 1, 1));
  endtask

  task automatic test_random(int n, int span_v);
    int v, l, r, k, m;
    set_span(span_v);
    m = eff_span();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: v = 32'h7fffffff;
        1: v = 32'h80000000;
        default: v = int'($urandom);
      endcase
      if (seq_len == 0 || $urandom_range(99) < 45) begin
        if ($urandom_range(19) == 0) send_beat(append_beat($urandom_range(4095), v));
        else send_beat(append_beat($urandom_range(m - 1), v));
      end else if ($urandom_range(19) == 0) begin
        send_beat(query_beat($urandom_range(8191), $urandom_range(8191),
                             $urandom_range(8191)));
      end else begin
        l = $urandom_range(seq_len, 1);
        r = $urandom_range(seq_len, l);
        k = $urandom_range(r - l + 2);
        send_beat(query_beat(l, r, k));
      end
    end
  endtask

  // receiver holds off while the sender keeps offering queries
  task automatic test_pressure();
    set_span(64);
    for (int i = 0; i < 20; i++) send_beat(append_beat($urandom_range(63), int'($urandom)));
    fork
      begin
        hold_off = 1'b1;
        repeat (500) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 20; i++) send_beat(query_beat(1, 20, $urandom_range(21)));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    hold_off = 1'b0;
    errors = 0;
    beats_sent = 0;
    results_seen = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    span_reg = rtks_pkg::MAX_RANKS;
    clear_tree();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(300, 4096);
    send_idle_pct = 61;
    test_random(250, 5);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    test_random(250, 300);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    test_random(250, 2);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_pressure();

    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d beats and %0d results: extremes, span limits,",
             beats_sent, results_seen);
    $display("random appends and queries under idling, stalls and a long hold-off");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rtks_pkg.sv
hw/rtl/rtks_node_mem.sv
hw/rtl/range_topk_sum_query.sv
hw/rtl/rtks_checker.sv
tb/sv/tb_top.sv
